>>> design/point_segment_distance_top_assert.svh
// assertion macros for the point to segment distance rtl
// depends on nothing; included by psd_queue, the only module that carries checks
`ifndef POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PSD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define PSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/psd_pkg.sv
// shared types and constants for the point to segment distance block
// depends on nothing
`timescale 1ns / 1ps
package psd_pkg;
   localparam int unsigned PSD_COORD_WIDTH  = 32;
   localparam int unsigned PSD_LIMB_WIDTH   = 32;
   localparam int unsigned PSD_MUL_LAT      = 5;
   localparam int unsigned PSD_REGION_WIDTH = 2;

   typedef enum logic [PSD_REGION_WIDTH-1:0] {
      REGION_START    = 2'd0,
      REGION_INTERIOR = 2'd1,
      REGION_END      = 2'd2
   } region_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } psd_qstat_type;
endpackage

>>> design/point_segment_distance_top.sv
// top level of the point to segment distance block
// depends on psd_pkg, psd_front, psd_queue and psd_back
//
// usage
//   request: drive the nine signed fixed point coordinates (query point, segment
//   start, segment end; z at zero for planar use) and raise start; the transfer
//   happens at a clock edge with start high and busy low
//   response: rsp_valid is high for exactly one cycle with rsp_distance (unsigned,
//   floor of the true distance, same scale) and rsp_region (nearest start,
//   interior foot, nearest end); the receiver cannot hold it off
//   throughput: one request per cycle, back to back, while busy is low
//   pipeline: product and classify pipeline, the two-entry queue, 2*COORD_WIDTH+2
//   divide stages and COORD_WIDTH+1 square root stages, one bit each
//   busy: raised only when the two-entry queue is full; the back end drains one
//   entry every cycle, so it stays low in steady operation
//   reset: synchronous, clears all valid state; requests in flight are dropped
//   a segment whose ends coincide gives the distance to its start, region start
`timescale 1ns / 1ps
module point_segment_distance_top #(
   parameter int unsigned COORD_WIDTH = psd_pkg::PSD_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_point_x,
   input  logic signed [COORD_WIDTH-1:0] req_point_y,
   input  logic signed [COORD_WIDTH-1:0] req_point_z,
   input  logic signed [COORD_WIDTH-1:0] req_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_start_z,
   input  logic signed [COORD_WIDTH-1:0] req_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_end_z,
   output logic                          rsp_valid,
   output logic [COORD_WIDTH:0]          rsp_distance,
   output logic [psd_pkg::PSD_REGION_WIDTH-1:0] rsp_region
);
   import psd_pkg::*;

   localparam int unsigned QDW = 6 * COORD_WIDTH + 6 + PSD_REGION_WIDTH;

   logic           accept;
   logic           push;
   logic           pop;
   logic [QDW-1:0] push_data;
   logic [QDW-1:0] pop_data;
   psd_qstat_type  q_stat;

   assign busy   = q_stat.full;
   assign accept = start & ~busy;

   psd_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock, .reset, .accept,
      .point_x(req_point_x), .point_y(req_point_y), .point_z(req_point_z),
      .start_x(req_start_x), .start_y(req_start_y), .start_z(req_start_z),
      .end_x(req_end_x), .end_y(req_end_y), .end_z(req_end_z),
      .push, .push_data
   );

   psd_queue #(.DATA_W(QDW)) u_queue (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .stat(q_stat)
   );

   psd_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock, .reset, .stat(q_stat), .pop_data, .pop,
      .rsp_valid, .rsp_distance, .rsp_region
   );
endmodule

>>> design/psd_mul.sv
// pipelined signed multiplier built from limb partial products
// depends on psd_pkg for the default limb width
`timescale 1ns / 1ps
module psd_mul #(
   parameter int unsigned A_W    = 33,
   parameter int unsigned B_W    = 33,
   parameter int unsigned LIMB_W = psd_pkg::PSD_LIMB_WIDTH
) (
   input  logic                     clock,
   input  logic signed [A_W-1:0]    a,
   input  logic signed [B_W-1:0]    b,
   output logic signed [A_W+B_W-1:0] p
);
   localparam int unsigned NA  = (A_W + LIMB_W - 1) / LIMB_W;
   localparam int unsigned NB  = (B_W + LIMB_W - 1) / LIMB_W;
   localparam int unsigned P_W = A_W + B_W;

   logic [A_W-1:0]         a_u;
   logic [B_W-1:0]         b_u;
   logic [NA*LIMB_W-1:0]   ua_in, ua_ff;
   logic [NB*LIMB_W-1:0]   ub_in, ub_ff;
   logic [2*LIMB_W-1:0]    pp_ff [NA][NB];
   logic [P_W-1:0]         row_in [NA];
   logic [P_W-1:0]         row_ff [NA];
   logic [P_W-1:0]         mag_in, mag_ff;
   logic [P_W-1:0]         p_ff;
   logic [4:1]             neg_ff;

   assign a_u = a;
   assign b_u = b;

   always_comb begin
      ua_in = '0;
      ub_in = '0;
      ua_in[A_W-1:0] = a_u[A_W-1] ? (~a_u + A_W'(1)) : a_u;
      ub_in[B_W-1:0] = b_u[B_W-1] ? (~b_u + B_W'(1)) : b_u;
   end

   always_ff @(posedge clock) begin
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      neg_ff[1] <= a_u[A_W-1] ^ b_u[B_W-1];
      neg_ff[2] <= neg_ff[1];
      neg_ff[3] <= neg_ff[2];
      neg_ff[4] <= neg_ff[3];
   end

   for (genvar i = 0; i < NA; i++) begin : g_row
      for (genvar j = 0; j < NB; j++) begin : g_col
         always_ff @(posedge clock) begin
            pp_ff[i][j] <= ua_ff[i*LIMB_W +: LIMB_W] * ub_ff[j*LIMB_W +: LIMB_W];
         end
      end
   end

   // partial products summed per row, then rows summed
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (P_W'(pp_ff[i][j]) << ((i + j) * LIMB_W));
         end
      end
   end

   always_comb begin
      mag_in = '0;
      for (int i = 0; i < NA; i++) begin
         mag_in = mag_in + row_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      mag_ff <= mag_in;
      p_ff   <= neg_ff[4] ? (~mag_ff + P_W'(1)) : mag_ff;
   end

   assign p = p_ff;
endmodule

>>> design/psd_front.sv
// front end: differences, products, region classification, dividend and divisor
// depends on psd_pkg and psd_mul
`timescale 1ns / 1ps
module psd_front #(
   parameter int unsigned COORD_WIDTH = psd_pkg::PSD_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  logic signed [COORD_WIDTH-1:0] start_x,
   input  logic signed [COORD_WIDTH-1:0] start_y,
   input  logic signed [COORD_WIDTH-1:0] start_z,
   input  logic signed [COORD_WIDTH-1:0] end_x,
   input  logic signed [COORD_WIDTH-1:0] end_y,
   input  logic signed [COORD_WIDTH-1:0] end_z,
   output logic                          push,
   output logic [6*COORD_WIDTH+6+psd_pkg::PSD_REGION_WIDTH-1:0] push_data
);
   import psd_pkg::*;

   localparam int unsigned W    = COORD_WIDTH;
   localparam int unsigned DIFW = W + 1;
   localparam int unsigned PW   = 2 * W + 2;
   localparam int unsigned DOTW = 2 * W + 3;
   localparam int unsigned SQW  = 2 * W + 2;
   localparam int unsigned CSW  = 4 * W + 2;
   localparam int unsigned NUMW = 4 * W + 4;
   localparam int unsigned DENW = 2 * W + 2;
   localparam int unsigned L    = PSD_MUL_LAT;
   localparam int unsigned LAST = 3 + 2 * L;

   logic signed [W-1:0]      pt [3];
   logic signed [W-1:0]      st [3];
   logic signed [W-1:0]      en [3];
   logic signed [DIFW-1:0]   v_ff [3];
   logic signed [DIFW-1:0]   d_ff [3];
   logic signed [DIFW-1:0]   e_ff [3];
   logic signed [PW-1:0]     m_vd [3];
   logic signed [PW-1:0]     m_dd [3];
   logic signed [PW-1:0]     m_vv [3];
   logic signed [PW-1:0]     m_ee [3];
   logic signed [PW-1:0]     m_xa [3];
   logic signed [PW-1:0]     m_xb [3];
   logic signed [2*PW-1:0]   m_sq [3];
   logic signed [DOTW-1:0]   dot_ff;
   logic [SQW-1:0]           len2_ff, vv_ff, ee_ff;
   logic signed [PW-1:0]     cr_ff [3];
   region_type               region_in;
   region_type               sreg_ff [0:L];
   logic [SQW-1:0]           svv_ff [0:L];
   logic [SQW-1:0]           see_ff [0:L];
   logic [SQW-1:0]           slen_ff [0:L];
   logic [NUMW-1:0]          cc_ff;
   logic [LAST:1]            vld_in, vld_ff;
   logic [NUMW-1:0]          num;
   logic [DENW-1:0]          den;

   assign pt[0] = point_x;
   assign pt[1] = point_y;
   assign pt[2] = point_z;
   assign st[0] = start_x;
   assign st[1] = start_y;
   assign st[2] = start_z;
   assign en[0] = end_x;
   assign en[1] = end_y;
   assign en[2] = end_z;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         v_ff[k] <= {pt[k][W-1], pt[k]} - {st[k][W-1], st[k]};
         d_ff[k] <= {en[k][W-1], en[k]} - {st[k][W-1], st[k]};
         e_ff[k] <= {pt[k][W-1], pt[k]} - {en[k][W-1], en[k]};
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_mul
      localparam int unsigned K1 = (k + 1) % 3;
      localparam int unsigned K2 = (k + 2) % 3;
      psd_mul #(.A_W(DIFW), .B_W(DIFW)) u_vd (.clock, .a(v_ff[k]), .b(d_ff[k]), .p(m_vd[k]));
      psd_mul #(.A_W(DIFW), .B_W(DIFW)) u_dd (.clock, .a(d_ff[k]), .b(d_ff[k]), .p(m_dd[k]));
      psd_mul #(.A_W(DIFW), .B_W(DIFW)) u_vv (.clock, .a(v_ff[k]), .b(v_ff[k]), .p(m_vv[k]));
      psd_mul #(.A_W(DIFW), .B_W(DIFW)) u_ee (.clock, .a(e_ff[k]), .b(e_ff[k]), .p(m_ee[k]));
      psd_mul #(.A_W(DIFW), .B_W(DIFW)) u_xa (.clock, .a(v_ff[K1]), .b(d_ff[K2]), .p(m_xa[k]));
      psd_mul #(.A_W(DIFW), .B_W(DIFW)) u_xb (.clock, .a(v_ff[K2]), .b(d_ff[K1]), .p(m_xb[k]));
      psd_mul #(.A_W(PW), .B_W(PW)) u_sq (.clock, .a(cr_ff[k]), .b(cr_ff[k]), .p(m_sq[k]));
   end

   always_ff @(posedge clock) begin
      dot_ff  <= DOTW'(m_vd[0]) + DOTW'(m_vd[1]) + DOTW'(m_vd[2]);
      len2_ff <= SQW'(m_dd[0]) + SQW'(m_dd[1]) + SQW'(m_dd[2]);
      vv_ff   <= SQW'(m_vv[0]) + SQW'(m_vv[1]) + SQW'(m_vv[2]);
      ee_ff   <= SQW'(m_ee[0]) + SQW'(m_ee[1]) + SQW'(m_ee[2]);
      for (int k = 0; k < 3; k++) begin
         cr_ff[k] <= m_xa[k] - m_xb[k];
      end
      cc_ff <= {2'b00, m_sq[0][CSW-1:0]} + {2'b00, m_sq[1][CSW-1:0]}
             + {2'b00, m_sq[2][CSW-1:0]};
   end

   // degenerate segment falls in with the nearest start case
   always_comb begin
      if (len2_ff == '0 || dot_ff[DOTW-1]) begin
         region_in = REGION_START;
      end else if (dot_ff > $signed({1'b0, len2_ff})) begin
         region_in = REGION_END;
      end else begin
         region_in = REGION_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      sreg_ff[0] <= region_in;
      svv_ff[0]  <= vv_ff;
      see_ff[0]  <= ee_ff;
      slen_ff[0] <= len2_ff;
      for (int s = 1; s <= L; s++) begin
         sreg_ff[s] <= sreg_ff[s-1];
         svv_ff[s]  <= svv_ff[s-1];
         see_ff[s]  <= see_ff[s-1];
         slen_ff[s] <= slen_ff[s-1];
      end
   end

   always_comb begin
      vld_in = {vld_ff[LAST-1:1], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      case (sreg_ff[L])
         REGION_START: begin
            num = NUMW'(svv_ff[L]);
            den = DENW'(1);
         end
         REGION_END: begin
            num = NUMW'(see_ff[L]);
            den = DENW'(1);
         end
         default: begin
            num = cc_ff;
            den = slen_ff[L];
         end
      endcase
   end

   assign push      = vld_ff[LAST];
   assign push_data = {sreg_ff[L], num, den};
endmodule

>>> design/psd_queue.sv
// two-entry queue between front end and back end
// depends on psd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "point_segment_distance_top_assert.svh"
module psd_queue #(
   parameter int unsigned DATA_W = 200
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [DATA_W-1:0]       push_data,
   input  logic                    pop,
   output logic [DATA_W-1:0]       pop_data,
   output psd_pkg::psd_qstat_type  stat
);
   import psd_pkg::*;

   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data       = mem_ff[rd_ptr_ff];
   assign stat.not_empty = (count_ff != 2'd0);
   assign stat.full      = (count_ff == 2'd2);

   `PSD_ASSERT_SAME(q_no_overflow, clock, reset, push && stat.full, pop, "queue overflow")
   `PSD_ASSERT_SAME(q_no_underflow, clock, reset, pop, stat.not_empty, "queue underflow")
   `PSD_ASSERT_NEXT(q_fill, clock, reset, push && !pop, stat.not_empty, "queue lost a transfer")
endmodule

>>> design/psd_back.sv
// back end: pipelined restoring divide then pipelined integer square root
// depends on psd_pkg
`timescale 1ns / 1ps
module psd_back #(
   parameter int unsigned COORD_WIDTH = psd_pkg::PSD_COORD_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  psd_pkg::psd_qstat_type        stat,
   input  logic [6*COORD_WIDTH+6+psd_pkg::PSD_REGION_WIDTH-1:0] pop_data,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [COORD_WIDTH:0]          rsp_distance,
   output logic [psd_pkg::PSD_REGION_WIDTH-1:0] rsp_region
);
   import psd_pkg::*;

   localparam int unsigned W    = COORD_WIDTH;
   localparam int unsigned NUMW = 4 * W + 4;
   localparam int unsigned DENW = 2 * W + 2;
   localparam int unsigned QW   = 2 * W + 2;
   localparam int unsigned N    = W + 1;
   localparam int unsigned RW   = N + 2;

   logic [NUMW-1:0]   acc_ff [0:QW];
   logic [DENW-1:0]   den_ff [0:QW];
   region_type        dreg_ff [0:QW];
   logic [QW:0]       dv_ff;
   logic [RW-1:0]     rem_w [0:N];
   logic [N-1:0]      res_w [0:N];
   logic [QW-1:0]     xs_w [0:N];
   region_type        sreg_w [0:N];
   logic [N:0]        sv_w;
   logic [RW-1:0]     rem_ff [1:N];
   logic [N-1:0]      res_ff [1:N];
   logic [QW-1:0]     xs_ff [1:N];
   region_type        sreg_ff [1:N];
   logic [N:1]        sv_ff;

   assign pop = stat.not_empty;

   always_ff @(posedge clock) begin
      acc_ff[0]  <= pop_data[DENW +: NUMW];
      den_ff[0]  <= pop_data[DENW-1:0];
      dreg_ff[0] <= region_type'(pop_data[NUMW+DENW +: PSD_REGION_WIDTH]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else begin
         dv_ff <= {dv_ff[QW-1:0], pop};
      end
   end

   // one quotient bit per stage, quotient bits enter at the bottom of the word
   for (genvar i = 0; i < QW; i++) begin : g_div
      logic [DENW:0]   top;
      logic [DENW+1:0] diff;
      logic            ge;
      logic [DENW-1:0] nrem;
      assign top  = acc_ff[i][NUMW-1:QW-1];
      assign diff = {1'b0, top} - {2'b00, den_ff[i]};
      assign ge   = ~diff[DENW+1];
      assign nrem = ge ? diff[DENW-1:0] : top[DENW-1:0];
      always_ff @(posedge clock) begin
         acc_ff[i+1]  <= {nrem, acc_ff[i][QW-2:0], ge};
         den_ff[i+1]  <= den_ff[i];
         dreg_ff[i+1] <= dreg_ff[i];
      end
   end

   assign rem_w[0]  = '0;
   assign res_w[0]  = '0;
   assign xs_w[0]   = acc_ff[QW][QW-1:0];
   assign sreg_w[0] = dreg_ff[QW];
   assign sv_w[0]   = dv_ff[QW];

   // one root bit per stage
   for (genvar j = 1; j <= N; j++) begin : g_sqrt
      logic [RW+1:0] t;
      logic [RW+2:0] diff;
      logic          ge;
      assign t    = {rem_w[j-1], xs_w[j-1][QW-1:QW-2]};
      assign diff = {1'b0, t} - {3'b000, res_w[j-1], 2'b01};
      assign ge   = ~diff[RW+2];
      always_ff @(posedge clock) begin
         rem_ff[j]  <= ge ? diff[RW-1:0] : t[RW-1:0];
         res_ff[j]  <= {res_w[j-1][N-2:0], ge};
         xs_ff[j]   <= {xs_w[j-1][QW-3:0], 2'b00};
         sreg_ff[j] <= sreg_w[j-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[j] <= 1'b0;
         end else begin
            sv_ff[j] <= sv_w[j-1];
         end
      end
      assign rem_w[j]  = rem_ff[j];
      assign res_w[j]  = res_ff[j];
      assign xs_w[j]   = xs_ff[j];
      assign sreg_w[j] = sreg_ff[j];
      assign sv_w[j]   = sv_ff[j];
   end

   assign rsp_valid    = sv_w[N];
   assign rsp_distance = res_w[N];
   assign rsp_region   = sreg_w[N];
endmodule

>>> tb/point_segment_distance_top_tb.sv
// self-checking testbench for the point to segment distance block
// depends on psd_pkg and point_segment_distance_top; directed table, then random queries
// each transfer is predicted with exact wide integer arithmetic and checked in order
`timescale 1ns / 1ps
module point_segment_distance_top_tb;
   import psd_pkg::*;

   localparam int CW = PSD_COORD_WIDTH;
   localparam int RANDOM_QUERIES = 1340;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 150;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [255:0] wide_type;
   typedef logic [CW:0] dist_type;

   typedef struct {
      coord_type  c[9];
      bit         known;
      dist_type   distance;
      region_type region;
   } query_row_type;

   typedef struct {
      dist_type   distance;
      region_type region;
   } distance_result_type;

   logic      clock, reset, start, busy, rsp_valid;
   coord_type req_point_x, req_point_y, req_point_z;
   coord_type req_start_x, req_start_y, req_start_z;
   coord_type req_end_x, req_end_y, req_end_z;
   dist_type  rsp_distance;
   logic [PSD_REGION_WIDTH-1:0] rsp_region;

   distance_result_type pending_results[$];
   query_row_type       directed_rows[$];
   int fail_count, query_count, result_count, idle_cycles;
   int region_hits[3];
   bit drain_done;

   point_segment_distance_top DUT (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic distance_result_type segment_distance(input coord_type c[9]);
      distance_result_type res;
      wide_type d[3], v[3], e[3], cr[3], dotp, len2, x;
      logic [255:0] cand;
      dist_type root;
      for (int k = 0; k < 3; k++) begin
         d[k] = wide_type'(c[6+k]) - wide_type'(c[3+k]);
         v[k] = wide_type'(c[k]) - wide_type'(c[3+k]);
         e[k] = wide_type'(c[k]) - wide_type'(c[6+k]);
      end
      dotp = v[0]*d[0] + v[1]*d[1] + v[2]*d[2];
      len2 = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
      if (len2 == 0 || dotp < 0) begin
         res.region = REGION_START;
         x = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
      end else if (dotp > len2) begin
         res.region = REGION_END;
         x = e[0]*e[0] + e[1]*e[1] + e[2]*e[2];
      end else begin
         res.region = REGION_INTERIOR;
         cr[0] = v[1]*d[2] - v[2]*d[1];
         cr[1] = v[2]*d[0] - v[0]*d[2];
         cr[2] = v[0]*d[1] - v[1]*d[0];
         x = $unsigned(cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2]) / $unsigned(len2);
      end
      root = '0;
      for (int b = CW; b >= 0; b--) begin
         cand = 256'(root) | (256'd1 << b);
         if (cand * cand <= $unsigned(x)) root = cand[CW:0];
      end
      res.distance = root;
      return res;
   endfunction

   function automatic query_row_type make_row(input coord_type p0, p1, p2, a0, a1, a2,
                                              b0, b1, b2, input bit known,
                                              input dist_type distance,
                                              input region_type region);
      query_row_type r;
      r.c = '{p0, p1, p2, a0, a1, a2, b0, b1, b2};
      r.known = known;
      r.distance = distance;
      r.region = region;
      return r;
   endfunction

   function automatic coord_type pick_coord(input int span);
      coord_type val;
      if (span >= CW) val = coord_type'($urandom);
      else val = coord_type'($urandom_range(0, (1 << (span+1)) - 1))
                 - (coord_type'(1) <<< span);
      return val;
   endfunction

   function automatic query_row_type random_query();
      query_row_type r;
      int kind, span;
      kind = $urandom_range(0, 9);
      span = (kind <= 2) ? CW : (kind == 9) ? 30 : $urandom_range(4, 22);
      for (int i = 0; i < 9; i++) r.c[i] = pick_coord(span);
      case (kind)
         6: begin
            r.c[2] = '0; r.c[5] = '0; r.c[8] = '0;
         end
         7: for (int k = 0; k < 3; k++) r.c[6+k] = r.c[3+k];
         8: begin
            if ($urandom_range(0, 1)) for (int k = 0; k < 3; k++) r.c[k] = r.c[3+k];
            else for (int k = 0; k < 3; k++) r.c[k] = r.c[6+k];
         end
         default: ;
      endcase
      r.known = 1'b0;
      return r;
   endfunction

   task automatic send_query(input query_row_type r, input int gap);
      distance_result_type res;
      req_point_x <= r.c[0]; req_point_y <= r.c[1]; req_point_z <= r.c[2];
      req_start_x <= r.c[3]; req_start_y <= r.c[4]; req_start_z <= r.c[5];
      req_end_x   <= r.c[6]; req_end_y   <= r.c[7]; req_end_z   <= r.c[8];
      start <= 1'b1;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      res = segment_distance(r.c);
      if (r.known && (res.distance !== r.distance || res.region !== r.region)) begin
         $display("%0t table row disagrees with prediction: expected %0d/%0d got %0d/%0d",
                  $time, r.distance, r.region, res.distance, res.region);
         fail_count++;
      end
      if (r.known) begin
         res.distance = r.distance;
         res.region = r.region;
      end
      pending_results.push_back(res);
      query_count++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result checking
   always @(posedge clock) begin
      distance_result_type want;
      if (!reset && rsp_valid) begin
         result_count++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected transfer: distance %0d region %0d",
                     $time, rsp_distance, rsp_region);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            region_hits[want.region]++;
            if (rsp_distance !== want.distance) begin
               $display("%0t distance mismatch: expected %0d actual %0d",
                        $time, want.distance, rsp_distance);
               fail_count++;
            end
            if (rsp_region !== want.region) begin
               $display("%0t region mismatch: expected %0d actual %0d",
                        $time, want.region, rsp_region);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || drain_done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      coord_type mx, mn, u;
      bit quiet;
      mx = {1'b0, {(CW-1){1'b1}}};
      mn = {1'b1, {(CW-1){1'b0}}};
      u = coord_type'(1) <<< 16;
      fail_count = 0; query_count = 0; result_count = 0; idle_cycles = 0;
      region_hits = '{0, 0, 0};
      drain_done = 1'b0;
      reset = 1'b1; start = 1'b0;
      {req_point_x, req_point_y, req_point_z} = '0;
      {req_start_x, req_start_y, req_start_z} = '0;
      {req_end_x, req_end_y, req_end_z} = '0;

      directed_rows.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, REGION_START));
      directed_rows.push_back(make_row(3*u, 4*u, 0, 0, 0, 0, 0, 0, 0, 1, 5*u, REGION_START));
      directed_rows.push_back(make_row(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1, 0, REGION_START));
      directed_rows.push_back(make_row(mn, mn, mn, mn, mn, mn, mn, mn, mn, 1, 0, REGION_START));
      directed_rows.push_back(make_row(-3*u, 4*u, 0, 0, 0, 0, 10*u, 0, 0, 1, 5*u,
                                       REGION_START));
      directed_rows.push_back(make_row(13*u, 4*u, 0, 0, 0, 0, 10*u, 0, 0, 1, 5*u, REGION_END));
      directed_rows.push_back(make_row(5*u, 7*u, 0, 0, 0, 0, 10*u, 0, 0, 1, 7*u,
                                       REGION_INTERIOR));
      // projection exactly at the start, then exactly at the end
      directed_rows.push_back(make_row(0, 7*u, 0, 0, 0, 0, 10*u, 0, 0, 1, 7*u,
                                       REGION_INTERIOR));
      directed_rows.push_back(make_row(10*u, 0, 7*u, 0, 0, 0, 10*u, 0, 0, 1, 7*u,
                                       REGION_INTERIOR));
      directed_rows.push_back(make_row(mx, mx, mx, mn, mn, mn, mn, mn, mn, 0, 0, REGION_START));
      directed_rows.push_back(make_row(mn, mn, mn, mx, mx, mx, mn, mn, mn, 0, 0, REGION_START));
      directed_rows.push_back(make_row(0, 0, 0, mn, mn, mn, mx, mx, mx, 0, 0, REGION_START));
      directed_rows.push_back(make_row(mx, mn, 0, mn, mn, mn, mx, mx, mx, 0, 0, REGION_START));
      directed_rows.push_back(make_row(mn, mx, mx, 0, mn, mx, mx, 0, mn, 0, 0, REGION_START));
      directed_rows.push_back(make_row(u, 2*u, 3*u, -u, 5*u, 1, 7*u, -3*u, u+5, 0, 0,
                                       REGION_START));
      directed_rows.push_back(make_row(-1, -1, -1, 0, 0, 0, 1, 1, 1, 0, 0, REGION_START));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_query(directed_rows[i], pick_gap(1'b0));

      quiet = 1'b0;
      for (int n = 0; n < RANDOM_QUERIES; n++) begin
         if (n % 100 == 0) quiet = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_QUERIES / 2) begin
            start <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         send_query(random_query(), pick_gap(quiet));
      end
      start <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      drain_done = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d queries sent, %0d results checked", query_count, result_count);
      $display("regions seen: start %0d, interior %0d, end %0d",
               region_hits[0], region_hits[1], region_hits[2]);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
